FILE: rtl/hsvcj_pkg.sv
package hsvcj_pkg;

   // Pixel channel width; all ones stands for 1.0
   localparam int PIX_W      = 16;
   // Unscaled saturation / sextant fraction, Q.16 up to and including 1.0
   localparam int SQ_W       = 17;
   localparam int GAIN_W     = 16;
   localparam int GAIN_SHIFT = 12;
   localparam int SP_W       = SQ_W + GAIN_W;          // saturation * gain
   localparam int SG_W       = SP_W - GAIN_SHIFT;      // scaled saturation
   localparam int VP_W       = PIX_W + GAIN_W;         // value * gain
   localparam int V_W        = VP_W - GAIN_SHIFT;      // scaled value
   localparam int ST_W       = SG_W + 1;               // s * (1 - f) >> 16
   localparam int H_W        = 19;                     // hue, full turn 6 * 65536
   localparam int F_W        = 16;                     // fraction within a sextant
   localparam int SEC_W      = H_W - F_W;
   localparam int M_W        = ST_W + 1;               // signed (1 - x) factors
   localparam int PR_W       = V_W + 1 + M_W;          // v * (1 - x) products
   localparam int CL_W       = PR_W - F_W;             // floored products
   localparam int DIV_STEPS  = SQ_W;
   localparam int OFS_W      = 16;

   localparam logic [H_W-1:0]   HUE_FULL = H_W'(6 * 65536);
   localparam logic [H_W-1:0]   HUE_SEXT = H_W'(65536);
   localparam logic [PIX_W-1:0] PIX_ONE  = '1;

   localparam logic [OFS_W-1:0]  RST_HUE_OFFSET = '0;
   localparam logic [GAIN_W-1:0] RST_GAIN       = GAIN_W'(4096);

   typedef enum logic [1:0] {
      CSR_HUE_OFFSET = 2'd0,
      CSR_SAT_GAIN   = 2'd1,
      CSR_VAL_GAIN   = 2'd2,
      CSR_SINGLE     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      HSEL_RED   = 3'b001,
      HSEL_GREEN = 3'b010,
      HSEL_BLUE  = 3'b100
   } hsel_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_data_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
   } rsp_data_type;

   // State carried through the two long-division chains
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] mx;
      logic [PIX_W-1:0] delta;
      hsel_type         hsel;
      logic             hneg;
      logic [PIX_W-1:0] srem;
      logic [SQ_W-1:0]  sq;
      logic [PIX_W-1:0] hrem;
      logic [SQ_W-1:0]  hq;
   } div_type;

   // One restoring division step: {quotient bit, new remainder}
   function automatic logic [PIX_W:0] div_step(input logic [PIX_W:0] rem,
                                               input logic [PIX_W-1:0] den);
      logic [PIX_W:0] d;
      logic [PIX_W:0] diff;
      d    = {1'b0, den};
      diff = rem - d;
      if (rem >= d) begin
         return {1'b1, diff[PIX_W-1:0]};
      end else begin
         return {1'b0, rem[PIX_W-1:0]};
      end
   endfunction

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [CL_W-1:0] x);
      logic signed [CL_W-1:0] top;
      top = $signed({{(CL_W-PIX_W){1'b0}}, PIX_ONE});
      if (x < 0) begin
         return '0;
      end else if (x > top) begin
         return PIX_ONE;
      end else begin
         return x[PIX_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/hsv_color_jitter.sv
// HSV color jitter. Each beat carries one RGB pixel (16-bit channels, all ones = 1.0);
// the block converts it to hue/saturation/value, scales saturation and value by the
// unsigned Q4.12 gains, rotates hue by the signed Q1.15 offset (wrapping within one
// turn), converts back and clamps every channel to 0 .. 1.0. With single_channel set,
// only red is scaled by the value gain; green and blue come back unchanged. A gray
// pixel gets hue 0. One pixel enters per clock while req_stall is low; the pipeline is
// 24 register stages. The depth is set by the two 17-step restoring dividers
// (saturation and sextant fraction) that run side by side, one quotient bit per
// stage. Every stage fills its bubble when the next one holds, so req_stall rises
// only while a result sits in the output register under rsp_stall and the whole
// chain is full.
// Configuration writes are always taken (csr_ready is tied high) and are meant for
// idle periods only.
module hsv_color_jitter
   import hsvcj_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_data_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_data_type  rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_data
);

   // ---------------------------------------------------------------- registers
   logic [OFS_W-1:0]  hue_offset_ff;
   logic [GAIN_W-1:0] sat_gain_ff;
   logic [GAIN_W-1:0] val_gain_ff;
   logic              single_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= RST_HUE_OFFSET;
         sat_gain_ff   <= RST_GAIN;
         val_gain_ff   <= RST_GAIN;
         single_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HUE_OFFSET: hue_offset_ff <= csr_data;
            CSR_SAT_GAIN:   sat_gain_ff   <= csr_data;
            CSR_VAL_GAIN:   val_gain_ff   <= csr_data;
            CSR_SINGLE:     single_ff     <= csr_data[0];
            default:        single_ff     <= single_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- enables
   // A stage advances when it is empty or the stage after it advances.
   logic                 a_vld_ff, b_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff, h_vld_ff;
   logic                 rsp_vld_ff;
   logic [DIV_STEPS-1:0] d_vld_ff;
   logic                 a_en, b_en, e_en, f_en, g_en, h_en, o_en;
   logic [DIV_STEPS-1:0] d_en;

   assign o_en = !rsp_vld_ff || !rsp_stall;
   assign h_en = !h_vld_ff || o_en;
   assign g_en = !g_vld_ff || h_en;
   assign f_en = !f_vld_ff || g_en;
   assign e_en = !e_vld_ff || f_en;
   assign b_en = !b_vld_ff || d_en[0];
   assign a_en = !a_vld_ff || b_en;

   assign req_stall = !a_en;

   // ---------------------------------------------------------------- stage A: capture
   req_data_type a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && req_valid) begin
         a_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------- stage B: max, min, hue numerator
   logic [PIX_W-1:0]      b_r, b_g, b_bl, b_mx, b_mn;
   logic signed [PIX_W:0] b_diff;
   hsel_type              b_hsel;
   div_type               b_in, b_ff;

   always_comb begin
      b_r  = a_ff.red_in;
      b_g  = a_ff.green_in;
      b_bl = a_ff.blue_in;
      b_mx = (b_r > b_g) ? ((b_r > b_bl) ? b_r : b_bl) : ((b_g > b_bl) ? b_g : b_bl);
      b_mn = (b_r < b_g) ? ((b_r < b_bl) ? b_r : b_bl) : ((b_g < b_bl) ? b_g : b_bl);
      // ties for the maximum go to red, then green
      priority if (b_r == b_mx) begin
         b_hsel = HSEL_RED;
         b_diff = $signed({1'b0, b_g}) - $signed({1'b0, b_bl});
      end else if (b_g == b_mx) begin
         b_hsel = HSEL_GREEN;
         b_diff = $signed({1'b0, b_bl}) - $signed({1'b0, b_r});
      end else begin
         b_hsel = HSEL_BLUE;
         b_diff = $signed({1'b0, b_r}) - $signed({1'b0, b_g});
      end
      b_in.red   = b_r;
      b_in.green = b_g;
      b_in.blue  = b_bl;
      b_in.mx    = b_mx;
      b_in.delta = b_mx - b_mn;
      b_in.hsel  = b_hsel;
      b_in.hneg  = b_diff[PIX_W];
      b_in.srem  = b_mx - b_mn;
      b_in.sq    = '0;
      b_in.hrem  = b_diff[PIX_W] ? PIX_W'(-b_diff) : b_diff[PIX_W-1:0];
      b_in.hq    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en && a_vld_ff) begin
         b_ff <= b_in;
      end
   end

   // ---------------------------------------------------------------- stages D: dividers
   // s = delta * 65536 / mx and frac = |diff| * 65536 / delta, one quotient bit a stage.
   // The numerator never exceeds the divisor, so the first step runs unshifted.
   div_type              d_src [DIV_STEPS];
   div_type              d_in  [DIV_STEPS];
   div_type              d_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0] d_src_vld;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [PIX_W:0] s_step, h_step;

      if (k == 0) begin : g_first
         assign d_src[k]     = b_ff;
         assign d_src_vld[k] = b_vld_ff;
         assign s_step = div_step({1'b0, d_src[k].srem}, d_src[k].mx);
         assign h_step = div_step({1'b0, d_src[k].hrem}, d_src[k].delta);
      end else begin : g_rest
         assign d_src[k]     = d_ff[k-1];
         assign d_src_vld[k] = d_vld_ff[k-1];
         assign s_step = div_step({d_src[k].srem, 1'b0}, d_src[k].mx);
         assign h_step = div_step({d_src[k].hrem, 1'b0}, d_src[k].delta);
      end

      if (k == DIV_STEPS - 1) begin : g_last_en
         assign d_en[k] = !d_vld_ff[k] || e_en;
      end else begin : g_mid_en
         assign d_en[k] = !d_vld_ff[k] || d_en[k+1];
      end

      always_comb begin
         d_in[k]      = d_src[k];
         d_in[k].srem = s_step[PIX_W-1:0];
         d_in[k].sq   = {d_src[k].sq[SQ_W-2:0], s_step[PIX_W]};
         d_in[k].hrem = h_step[PIX_W-1:0];
         d_in[k].hq   = {d_src[k].hq[SQ_W-2:0], h_step[PIX_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[k] <= 1'b0;
         end else if (d_en[k]) begin
            d_vld_ff[k] <= d_src_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (d_en[k] && d_src_vld[k]) begin
            d_ff[k] <= d_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- stage E: gains, hue assembly
   div_type               e_src;
   logic [SQ_W-1:0]       e_sraw;
   logic [SP_W-1:0]       e_sprod;
   logic [VP_W-1:0]       e_vprod, e_rprod;
   logic signed [H_W:0]   e_base, e_frac, e_hsig;
   logic [SG_W-1:0]       e_s_in, e_s_ff;
   logic [V_W-1:0]        e_v_in, e_v_ff, e_rs_in, e_rs_ff;
   logic [H_W-1:0]        e_h_in, e_h_ff;
   logic [PIX_W-1:0]      e_g_ff, e_b_ff;

   always_comb begin
      e_src   = d_ff[DIV_STEPS-1];
      // black pixel: saturation 0
      e_sraw  = (e_src.mx != '0) ? e_src.sq : '0;
      e_sprod = SP_W'(e_sraw) * SP_W'(sat_gain_ff);
      e_vprod = VP_W'(e_src.mx) * VP_W'(val_gain_ff);
      e_rprod = VP_W'(e_src.red) * VP_W'(val_gain_ff);
      e_s_in  = e_sprod[SP_W-1:GAIN_SHIFT];
      e_v_in  = e_vprod[VP_W-1:GAIN_SHIFT];
      e_rs_in = e_rprod[VP_W-1:GAIN_SHIFT];

      unique case (e_src.hsel)
         HSEL_RED:   e_base = '0;
         HSEL_GREEN: e_base = $signed({1'b0, HUE_SEXT << 1});
         HSEL_BLUE:  e_base = $signed({1'b0, HUE_SEXT << 2});
         default:    e_base = '0;
      endcase
      e_frac = $signed({{(H_W+1-SQ_W){1'b0}}, e_src.hq});
      e_hsig = e_src.hneg ? (e_base - e_frac) : (e_base + e_frac);
      if (e_hsig < 0) begin
         e_hsig = e_hsig + $signed({1'b0, HUE_FULL});
      end
      // gray pixel: hue 0
      e_h_in = (e_src.delta != '0) ? e_hsig[H_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (e_en) begin
         e_vld_ff <= d_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (e_en && d_vld_ff[DIV_STEPS-1]) begin
         e_s_ff  <= e_s_in;
         e_v_ff  <= e_v_in;
         e_rs_ff <= e_rs_in;
         e_h_ff  <= e_h_in;
         e_g_ff  <= e_src.green;
         e_b_ff  <= e_src.blue;
      end
   end

   // ---------------------------------------------------------------- stage F: hue offset and wrap
   logic signed [H_W+1:0] f_ofs, f_ofs12, f_sum;
   logic [H_W-1:0]        f_h_in, f_h_ff;
   logic [SG_W-1:0]       f_s_ff;
   logic [V_W-1:0]        f_v_ff, f_rs_ff;
   logic [PIX_W-1:0]      f_g_ff, f_b_ff;

   always_comb begin
      f_ofs   = $signed({{(H_W+2-OFS_W){hue_offset_ff[OFS_W-1]}}, hue_offset_ff});
      // offset * 12 turns Q1.15 of a full turn into sextant units
      f_ofs12 = (f_ofs <<< 3) + (f_ofs <<< 2);
      f_sum   = $signed({2'b00, e_h_ff}) + f_ofs12;
      priority if (f_sum >= $signed({2'b00, HUE_FULL})) begin
         f_sum = f_sum - $signed({2'b00, HUE_FULL});
      end else if (f_sum < 0) begin
         f_sum = f_sum + $signed({2'b00, HUE_FULL});
      end
      f_h_in = f_sum[H_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (f_en) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en && e_vld_ff) begin
         f_h_ff  <= f_h_in;
         f_s_ff  <= e_s_ff;
         f_v_ff  <= e_v_ff;
         f_rs_ff <= e_rs_ff;
         f_g_ff  <= e_g_ff;
         f_b_ff  <= e_b_ff;
      end
   end

   // ---------------------------------------------------------------- stage G: s*f, s*(1-f), v*(1-s)
   logic [F_W-1:0]          g_f;
   logic [F_W:0]            g_fc;
   logic [SG_W+F_W-1:0]     g_sfprod;
   logic [SG_W+F_W:0]       g_stprod;
   logic signed [M_W-1:0]   g_pm;
   logic signed [V_W:0]     g_vs;
   logic signed [PR_W-1:0]  g_pprod_in, g_pprod_ff;
   logic [SG_W-1:0]         g_sf_ff;
   logic [ST_W-1:0]         g_st_ff;
   logic [SEC_W-1:0]        g_sec_ff;
   logic                    g_szero_ff;
   logic [V_W-1:0]          g_v_ff, g_rs_ff;
   logic [PIX_W-1:0]        g_g_ff, g_b_ff;

   always_comb begin
      g_f        = f_h_ff[F_W-1:0];
      g_fc       = (F_W+1)'(HUE_SEXT) - (F_W+1)'(g_f);
      g_sfprod   = (SG_W+F_W)'(f_s_ff) * (SG_W+F_W)'(g_f);
      g_stprod   = (SG_W+F_W+1)'(f_s_ff) * (SG_W+F_W+1)'(g_fc);
      g_pm       = $signed(M_W'(HUE_SEXT)) - $signed({{(M_W-SG_W){1'b0}}, f_s_ff});
      g_vs       = $signed({1'b0, f_v_ff});
      g_pprod_in = g_vs * g_pm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (g_en) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (g_en && f_vld_ff) begin
         g_sf_ff    <= g_sfprod[SG_W+F_W-1:F_W];
         g_st_ff    <= g_stprod[SG_W+F_W:F_W];
         g_pprod_ff <= g_pprod_in;
         g_sec_ff   <= f_h_ff[H_W-1:F_W];
         g_szero_ff <= (f_s_ff == '0);
         g_v_ff     <= f_v_ff;
         g_rs_ff    <= f_rs_ff;
         g_g_ff     <= f_g_ff;
         g_b_ff     <= f_b_ff;
      end
   end

   // ---------------------------------------------------------------- stage H: q and t products
   logic signed [M_W-1:0]  h_qm, h_tm;
   logic signed [V_W:0]    h_vs;
   logic signed [PR_W-1:0] h_qprod, h_tprod;
   logic signed [CL_W-1:0] h_p_ff, h_q_ff, h_t_ff;
   logic [SEC_W-1:0]       h_sec_ff;
   logic                   h_szero_ff;
   logic [V_W-1:0]         h_v_ff, h_rs_ff;
   logic [PIX_W-1:0]       h_g_ff, h_b_ff;

   always_comb begin
      h_qm    = $signed(M_W'(HUE_SEXT)) - $signed({{(M_W-SG_W){1'b0}}, g_sf_ff});
      h_tm    = $signed(M_W'(HUE_SEXT)) - $signed({{(M_W-ST_W){1'b0}}, g_st_ff});
      h_vs    = $signed({1'b0, g_v_ff});
      h_qprod = h_vs * h_qm;
      h_tprod = h_vs * h_tm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (h_en) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   // floor to Q.16: keep the upper bits of the signed products
   always_ff @(posedge clock) begin
      if (h_en && g_vld_ff) begin
         h_p_ff     <= g_pprod_ff[PR_W-1:F_W];
         h_q_ff     <= h_qprod[PR_W-1:F_W];
         h_t_ff     <= h_tprod[PR_W-1:F_W];
         h_sec_ff   <= g_sec_ff;
         h_szero_ff <= g_szero_ff;
         h_v_ff     <= g_v_ff;
         h_rs_ff    <= g_rs_ff;
         h_g_ff     <= g_g_ff;
         h_b_ff     <= g_b_ff;
      end
   end

   // ---------------------------------------------------------------- stage O: sector select, clamp
   logic signed [CL_W-1:0] o_v, o_rs, o_ro, o_go, o_bo;
   rsp_data_type           rsp_in, rsp_ff;

   always_comb begin
      o_v  = $signed({{(CL_W-V_W){1'b0}}, h_v_ff});
      o_rs = $signed({{(CL_W-V_W){1'b0}}, h_rs_ff});
      if (h_szero_ff) begin
         o_ro = o_v;
         o_go = o_v;
         o_bo = o_v;
      end else begin
         unique case (h_sec_ff)
            SEC_W'(0): begin o_ro = o_v;    o_go = h_t_ff; o_bo = h_p_ff; end
            SEC_W'(1): begin o_ro = h_q_ff; o_go = o_v;    o_bo = h_p_ff; end
            SEC_W'(2): begin o_ro = h_p_ff; o_go = o_v;    o_bo = h_t_ff; end
            SEC_W'(3): begin o_ro = h_p_ff; o_go = h_q_ff; o_bo = o_v;    end
            SEC_W'(4): begin o_ro = h_t_ff; o_go = h_p_ff; o_bo = o_v;    end
            default:   begin o_ro = o_v;    o_go = h_p_ff; o_bo = h_q_ff; end
         endcase
      end
      if (single_ff) begin
         // red scaled by the value gain only; green and blue pass through
         rsp_in.red_out   = clamp_pix(o_rs);
         rsp_in.green_out = h_g_ff;
         rsp_in.blue_out  = h_b_ff;
      end else begin
         rsp_in.red_out   = clamp_pix(o_ro);
         rsp_in.green_out = clamp_pix(o_go);
         rsp_in.blue_out  = clamp_pix(o_bo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (o_en) begin
         rsp_vld_ff <= h_vld_ff;
      end
   end

   // hold the result beat while stalled
   always_ff @(posedge clock) begin
      if (o_en && h_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- assertions
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_vld_ff && rsp_stall))
      else $error("input stalled without output back-pressure");

   a_result_advances: assert property (@(posedge clock) disable iff (reset)
      (h_vld_ff && o_en) |=> rsp_vld_ff)
      else $error("finished pixel dropped before the result register");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_stall && !h_vld_ff) |=> !rsp_vld_ff)
      else $error("result beat repeated");

   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      f_vld_ff |-> (f_h_ff < HUE_FULL))
      else $error("hue outside one turn after wrap");

endmodule
